@@ hdl/piast_pkg.sv @@
`timescale 1ns / 1ps

package piast_pkg;

    localparam int CORDIC_STAGES   = 24;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int TABLE_FRAC      = 24;
    localparam int TABLE_LEN       = 40;
    localparam int PRESCALE_BITS   = 24;

    localparam int COORD_W = 32;
    localparam int DELTA_W = COORD_W + 1;
    localparam int XY_W    = DELTA_W + PRESCALE_BITS + 4;
    localparam int ANGLE_W = ANGLE_FRAC_BITS + 11;
    localparam int DIFF_W  = ANGLE_W + 1;
    localparam int START_W = 9;
    localparam int SWEEP_W = 10;
    localparam int CFG_DATA_W = 32;

    localparam int LATENCY = CORDIC_STAGES + 4;

    localparam logic signed [ANGLE_W-1:0] HALF_TURN =
        ANGLE_W'(longint'(180) << ANGLE_FRAC_BITS);
    localparam logic signed [DIFF_W-1:0] FULL_TURN =
        DIFF_W'(longint'(360) << ANGLE_FRAC_BITS);

    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_START    = 2'd2,
        CFG_SWEEP    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic valid;
        logic zero;
    } tag_t;

    localparam longint ATAN_Q24 [TABLE_LEN] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    function automatic logic signed [ANGLE_W-1:0] stage_angle(input int i);
        int     sh;
        longint t;
        sh = TABLE_FRAC - ANGLE_FRAC_BITS;
        t  = 0;
        if (i < TABLE_LEN)
        begin
            t = ATAN_Q24[i];
            if (sh > 0)
            begin
                t = (t + (longint'(1) << (sh - 1))) >>> sh;
            end
        end
        return ANGLE_W'(t);
    endfunction

endpackage

@@ hdl/piast_cordic.sv @@
`timescale 1ns / 1ps

module piast_cordic (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    input  logic signed [piast_pkg::DELTA_W-1:0]       dx,
    input  logic signed [piast_pkg::DELTA_W-1:0]       dy,
    output piast_pkg::tag_t                            tag,
    output logic signed [piast_pkg::ANGLE_W-1:0]       angle
);

    localparam int N = piast_pkg::CORDIC_STAGES;

    logic                                     valid_reg [0:N];
    logic                                     zero_reg  [0:N];
    logic signed [piast_pkg::XY_W-1:0]        x_reg     [0:N];
    logic signed [piast_pkg::XY_W-1:0]        y_reg     [0:N];
    logic signed [piast_pkg::ANGLE_W-1:0]     z_reg     [0:N];

    logic                                     is_zero;
    logic                                     flip;
    logic signed [piast_pkg::DELTA_W-1:0]     dx_rot;
    logic signed [piast_pkg::DELTA_W-1:0]     dy_rot;
    logic signed [piast_pkg::XY_W-1:0]        x_next;
    logic signed [piast_pkg::XY_W-1:0]        y_next;
    logic signed [piast_pkg::ANGLE_W-1:0]     z_next;

    always_comb
    begin
        is_zero = (dx == '0) && (dy == '0);
        flip    = dx[piast_pkg::DELTA_W-1];
        dx_rot  = flip ? -dx : dx;
        dy_rot  = flip ? -dy : dy;
        x_next  = $signed({(piast_pkg::XY_W - piast_pkg::DELTA_W - piast_pkg::PRESCALE_BITS)'(
                      {(piast_pkg::XY_W){dx_rot[piast_pkg::DELTA_W-1]}}),
                      dx_rot, {piast_pkg::PRESCALE_BITS{1'b0}}});
        y_next  = $signed({(piast_pkg::XY_W - piast_pkg::DELTA_W - piast_pkg::PRESCALE_BITS)'(
                      {(piast_pkg::XY_W){dy_rot[piast_pkg::DELTA_W-1]}}),
                      dy_rot, {piast_pkg::PRESCALE_BITS{1'b0}}});
        if (!flip)
        begin
            z_next = '0;
        end
        else if (!dy[piast_pkg::DELTA_W-1])
        begin
            z_next = piast_pkg::HALF_TURN;
        end
        else
        begin
            z_next = -piast_pkg::HALF_TURN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= is_zero;
        x_reg[0]    <= x_next;
        y_reg[0]    <= y_next;
        z_reg[0]    <= z_next;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        localparam logic signed [piast_pkg::ANGLE_W-1:0] ANG = piast_pkg::stage_angle(i);

        logic signed [piast_pkg::XY_W-1:0] xs;
        logic signed [piast_pkg::XY_W-1:0] ys;
        logic                              up;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        assign up = (y_reg[i] > 0);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            zero_reg[i+1] <= zero_reg[i];
            x_reg[i+1]    <= up ? x_reg[i] + ys : x_reg[i] - ys;
            y_reg[i+1]    <= up ? y_reg[i] - xs : y_reg[i] + xs;
            z_reg[i+1]    <= up ? z_reg[i] + ANG : z_reg[i] - ANG;
        end
    end

    assign tag.valid = valid_reg[N];
    assign tag.zero  = zero_reg[N];
    assign angle     = z_reg[N];

    a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[N] |-> !x_reg[N][piast_pkg::XY_W-1])
        else $error("cordic x went negative");

endmodule

@@ hdl/point_in_arc_sweep_test_top.sv @@
`timescale 1ns / 1ps

// Channel      Handshake                 Payload
// item in      start, busy               point_x, point_y
// result out   done (one-cycle strobe)   within_res
// config       cfg_valid, cfg_ready      cfg_index, cfg_data
//
// One point enters in every cycle; busy stays low.
// Each result passes through these pipeline stages after its point is taken:
// one delta stage, one pre-rotation stage, one stage per CORDIC iteration,
// then a range-offset stage and a compare stage.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// The receiver cannot stall, so the pipeline never holds.

module point_in_arc_sweep_test_top (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic signed [piast_pkg::COORD_W-1:0]     point_x,
    input  logic signed [piast_pkg::COORD_W-1:0]     point_y,
    output logic                                     done,
    output logic                                     within_res,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [1:0]                               cfg_index,
    input  logic [piast_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int FB = piast_pkg::ANGLE_FRAC_BITS;
    localparam int DW = piast_pkg::DIFF_W;

    logic signed [piast_pkg::COORD_W-1:0]  center_x_reg;
    logic signed [piast_pkg::COORD_W-1:0]  center_y_reg;
    logic [piast_pkg::START_W-1:0]         start_reg;
    logic signed [piast_pkg::SWEEP_W-1:0]  sweep_reg;

    logic [8:0]                            a0m_reg;
    logic [8:0]                            a0m_next;
    logic [piast_pkg::SWEEP_W-1:0]         mag_reg;
    logic [piast_pkg::SWEEP_W-1:0]         mag_next;

    logic signed [11:0]                    a0_raw;
    logic [11:0]                           a0_pos;

    logic                                  d_valid_reg;
    logic signed [piast_pkg::DELTA_W-1:0]  dx_reg;
    logic signed [piast_pkg::DELTA_W-1:0]  dy_reg;

    piast_pkg::tag_t                       c_tag;
    logic signed [piast_pkg::ANGLE_W-1:0]  c_angle;

    logic                                  f_valid_reg;
    logic signed [DW-1:0]                  diff_reg;
    logic signed [DW-1:0]                  diff_next;
    logic signed [DW-1:0]                  a0_scaled;
    logic signed [DW-1:0]                  mag_scaled;
    logic signed [DW-1:0]                  r_mod;

    logic                                  done_reg;
    logic                                  within_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            start_reg    <= '0;
            sweep_reg    <= piast_pkg::SWEEP_W'(90);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (piast_pkg::cfg_index_t'(cfg_index))
                piast_pkg::CFG_CENTER_X: center_x_reg <= $signed(cfg_data);
                piast_pkg::CFG_CENTER_Y: center_y_reg <= $signed(cfg_data);
                piast_pkg::CFG_START:    start_reg    <= cfg_data[piast_pkg::START_W-1:0];
                piast_pkg::CFG_SWEEP:    sweep_reg    <= $signed(cfg_data[piast_pkg::SWEEP_W-1:0]);
            endcase
        end
    end

    // reduce the low bound into 0..359
    always_comb
    begin
        a0_raw = $signed({3'b000, start_reg});
        if (!(sweep_reg > 0))
        begin
            a0_raw = a0_raw + 12'(sweep_reg);
        end
        a0_pos = unsigned'(a0_raw + 12'sd720);
        if (a0_pos >= 12'd1440)
        begin
            a0_pos = a0_pos - 12'd1440;
        end
        if (a0_pos >= 12'd720)
        begin
            a0_pos = a0_pos - 12'd720;
        end
        if (a0_pos >= 12'd360)
        begin
            a0_pos = a0_pos - 12'd360;
        end
        a0m_next = a0_pos[8:0];
        mag_next = sweep_reg[piast_pkg::SWEEP_W-1] ? unsigned'(-sweep_reg)
                                                   : unsigned'(sweep_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a0m_reg <= '0;
            mag_reg <= piast_pkg::SWEEP_W'(90);
        end
        else
        begin
            a0m_reg <= a0m_next;
            mag_reg <= mag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            d_valid_reg <= start && !busy;
            f_valid_reg <= c_tag.valid;
            done_reg    <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= piast_pkg::DELTA_W'(point_x) - piast_pkg::DELTA_W'(center_x_reg);
        dy_reg <= piast_pkg::DELTA_W'(point_y) - piast_pkg::DELTA_W'(center_y_reg);
    end

    piast_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (d_valid_reg),
        .dx       (dx_reg),
        .dy       (dy_reg),
        .tag      (c_tag),
        .angle    (c_angle)
    );

    always_comb
    begin
        a0_scaled  = $signed(DW'({a0m_reg, {FB{1'b0}}}));
        mag_scaled = $signed(DW'({mag_reg, {FB{1'b0}}}));
        diff_next  = c_tag.zero ? -a0_scaled : DW'(c_angle) - a0_scaled;
        if (diff_reg < -piast_pkg::FULL_TURN)
        begin
            r_mod = diff_reg + (piast_pkg::FULL_TURN <<< 1);
        end
        else if (diff_reg < 0)
        begin
            r_mod = diff_reg + piast_pkg::FULL_TURN;
        end
        else
        begin
            r_mod = diff_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            within_reg <= 1'b0;
        end
        else if (f_valid_reg)
        begin
            within_reg <= (r_mod < mag_scaled);
        end
    end

    assign done       = done_reg;
    assign within_res = within_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(piast_pkg::LATENCY) done)
        else $error("accepted transaction produced no result strobe");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, piast_pkg::LATENCY))
        else $error("result strobe out of step with accepted transaction");

    a_bound_range: assert property (@(posedge clk) disable iff (!rst_n)
        a0m_reg < 9'd360)
        else $error("low bound not reduced");

    a_zero_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        done && (mag_reg == '0) |-> !within_res)
        else $error("zero sweep reported a hit");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        !f_valid_reg |=> $stable(within_reg))
        else $error("result changed without a transaction");

endmodule

@@ bench/point_in_arc_sweep_test_checker.sv @@
`timescale 1ns / 1ps

module point_in_arc_sweep_test_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic signed [piast_pkg::COORD_W-1:0] point_x,
    input  logic signed [piast_pkg::COORD_W-1:0] point_y,
    input  logic                                 done,
    input  logic                                 within_res,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [1:0]                           cfg_index,
    input  logic [piast_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                   fail_count,
    output int                                   pending
);

    localparam int ATAN_FRAC   = 24;
    localparam int ATAN_N      = 40;
    localparam int PRESHIFT    = 24;
    localparam int FRAC        = piast_pkg::ANGLE_FRAC_BITS;

    localparam longint ATAN_DEG_Q24 [ATAN_N] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    longint             arc_cx;
    longint             arc_cy;
    logic [8:0]         arc_start;
    logic signed [9:0]  arc_sweep;
    logic               within_expected [$];
    logic               within_oldest;

    function automatic longint atan_step(input int i);
        int     sh;
        longint t;
        sh = ATAN_FRAC - FRAC;
        if (i >= ATAN_N)
        begin
            return 0;
        end
        t = ATAN_DEG_Q24[i];
        if (sh > 0)
        begin
            return (t + (longint'(1) <<< (sh - 1))) >>> sh;
        end
        if (sh < 0)
        begin
            return t * (longint'(1) <<< (-sh));
        end
        return t;
    endfunction

    function automatic longint vector_angle(input longint dx, input longint dy);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (dx == 0 && dy == 0)
        begin
            return 0;
        end
        if (dx < 0)
        begin
            z  = (dy >= 0) ? (longint'(180) <<< FRAC)
                           : -(longint'(180) <<< FRAC);
            dx = -dx;
            dy = -dy;
        end
        x = dx * (longint'(1) <<< PRESHIFT);
        y = dy * (longint'(1) <<< PRESHIFT);
        for (int i = 0; i < piast_pkg::CORDIC_STAGES && i < 63; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic logic arc_contains(input longint px, input longint py);
        longint one;
        longint full;
        longint angle;
        longint st;
        longint sw;
        longint a0;
        longint mag;
        longint r;
        one   = longint'(1) <<< FRAC;
        full  = 360 * one;
        angle = vector_angle(px - arc_cx, py - arc_cy);
        st    = longint'(arc_start);
        sw    = longint'(arc_sweep);
        a0    = (sw > 0) ? st : st + sw;
        mag   = (sw < 0) ? -sw : sw;
        r     = (angle - a0 * one) % full;
        if (r < 0)
        begin
            r = r + full;
        end
        return r < mag * one;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arc_cx     = 0;
            arc_cy     = 0;
            arc_start  = 9'd0;
            arc_sweep  = 10'sd90;
            within_expected.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                within_expected.push_back(arc_contains(longint'(point_x), longint'(point_y)));
            end
            if (done)
            begin
                if (within_expected.size() == 0)
                begin
                    $error("within_res: unexpected transaction, expected none, actual %0b",
                           within_res);
                    fail_count++;
                end
                else
                begin
                    within_oldest = within_expected.pop_front();
                    if (within_res !== within_oldest)
                    begin
                        $error("within_res mismatch: expected %0b, actual %0b",
                               within_oldest, within_res);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (piast_pkg::cfg_index_t'(cfg_index))
                    piast_pkg::CFG_CENTER_X: arc_cx    = longint'($signed(cfg_data));
                    piast_pkg::CFG_CENTER_Y: arc_cy    = longint'($signed(cfg_data));
                    piast_pkg::CFG_START:    arc_start = cfg_data[8:0];
                    piast_pkg::CFG_SWEEP:    arc_sweep = cfg_data[9:0];
                    default:                 ;
                endcase
            end
            pending = within_expected.size();
        end
    end

endmodule

@@ bench/tb_point_in_arc_sweep_test_top.sv @@
`timescale 1ns / 1ps

module tb_point_in_arc_sweep_test_top;

    localparam int NUM_PHASES   = 12;
    localparam int PHASE_POINTS = 36;
    localparam int EDGE_N       = 20;

    localparam int EDGE_X [EDGE_N] = '{
        0, 1, 0, -1, 0, 1, -1, -1, 1, 32'h7fff_ffff,
        32'h8000_0000, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
        32'h7fff_ffff, 5, -7, 3
    };
    localparam int EDGE_Y [EDGE_N] = '{
        0, 0, 1, 0, -1, 1, 1, -1, -1, 0,
        0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
        32'h7fff_ffff, 32'h8000_0000, -3, 2, 1000000
    };

    logic                                   clk = 1'b0;
    logic                                   rst_n;
    logic                                   start;
    logic                                   busy;
    logic signed [piast_pkg::COORD_W-1:0]   point_x;
    logic signed [piast_pkg::COORD_W-1:0]   point_y;
    logic                                   done;
    logic                                   within_res;
    logic                                   cfg_valid;
    logic                                   cfg_ready;
    piast_pkg::cfg_index_t                  cfg_index;
    logic [piast_pkg::CFG_DATA_W-1:0]       cfg_data;
    int                                     fail_count;
    int                                     pending;
    int                                     idle_pct;

    always #1 clk = ~clk;

    point_in_arc_sweep_test_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .point_x    (point_x),
        .point_y    (point_y),
        .done       (done),
        .within_res (within_res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    point_in_arc_sweep_test_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .point_x    (point_x),
        .point_y    (point_y),
        .done       (done),
        .within_res (within_res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    task automatic send_point(input int px, input int py);
        while ($urandom_range(99) < idle_pct)
        begin
            start   <= 1'b0;
            point_x <= $urandom;
            point_y <= $urandom;
            @(negedge clk);
        end
        start   <= 1'b1;
        point_x <= px;
        point_y <= py;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_reg(input piast_pkg::cfg_index_t idx,
                             input logic [piast_pkg::CFG_DATA_W-1:0] val);
        while ($urandom_range(99) < 30)
        begin
            cfg_valid <= 1'b0;
            @(negedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        int                     cx_v;
        int                     cy_v;
        int                     st_v;
        int                     sw_v;
        int                     px;
        int                     py;
        int                     d;
        int                     rot;
        piast_pkg::cfg_index_t  idx;

        rst_n     = 1'b0;
        start     = 1'b0;
        point_x   = '0;
        point_y   = '0;
        cfg_valid = 1'b0;
        cfg_index = piast_pkg::CFG_CENTER_X;
        cfg_data  = '0;
        idle_pct  = 30;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < EDGE_N; i++)
        begin
            send_point(EDGE_X[i], EDGE_Y[i]);
        end
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    cx_v = 32'h7fff_ffff; cy_v = 32'h8000_0000; st_v = 359; sw_v = -360;
                end
                1:
                begin
                    cx_v = 32'h8000_0000; cy_v = 32'h7fff_ffff; st_v = 0; sw_v = 0;
                end
                2:
                begin
                    cx_v = 0; cy_v = 0; st_v = 511; sw_v = 511;
                end
                3:
                begin
                    cx_v = 0; cy_v = 0; st_v = 0; sw_v = -512;
                end
                4:
                begin
                    cx_v = 17; cy_v = -23; st_v = 45; sw_v = 1;
                end
                5:
                begin
                    cx_v = -100; cy_v = 100; st_v = 300; sw_v = -1;
                end
                6:
                begin
                    cx_v = $urandom; cy_v = $urandom; st_v = 180; sw_v = 360;
                end
                default:
                begin
                    case ($urandom_range(2))
                        0:
                        begin
                            cx_v = 0; cy_v = 0;
                        end
                        1:
                        begin
                            cx_v = $urandom_range(2000) - 1000;
                            cy_v = $urandom_range(2000) - 1000;
                        end
                        default:
                        begin
                            cx_v = $urandom; cy_v = $urandom;
                        end
                    endcase
                    st_v = ($urandom_range(9) == 0) ? $urandom_range(511, 360)
                                                    : $urandom_range(359);
                    sw_v = $urandom_range(720) - 360;
                end
            endcase

            rot = $urandom_range(3);
            for (int j = 0; j < 4; j++)
            begin
                idx = piast_pkg::cfg_index_t'((j + rot) % 4);
                case (idx)
                    piast_pkg::CFG_CENTER_X: write_reg(idx, cx_v);
                    piast_pkg::CFG_CENTER_Y: write_reg(idx, cy_v);
                    piast_pkg::CFG_START:    write_reg(idx, {23'($urandom), 9'(st_v)});
                    default:                 write_reg(idx, {22'($urandom), 10'(sw_v)});
                endcase
            end
            cfg_valid <= 1'b0;

            idle_pct = (ph % 4 == 3) ? 0 : 30;
            for (int n = 0; n < PHASE_POINTS; n++)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4:
                    begin
                        px = $urandom;
                        py = $urandom;
                    end
                    5, 6, 7:
                    begin
                        px = cx_v + $urandom_range(2000) - 1000;
                        py = cy_v + $urandom_range(2000) - 1000;
                    end
                    8:
                    begin
                        d = $urandom_range(2000) - 1000;
                        case ($urandom_range(3))
                            0:
                            begin
                                px = cx_v + d; py = cy_v;
                            end
                            1:
                            begin
                                px = cx_v; py = cy_v + d;
                            end
                            2:
                            begin
                                px = cx_v + d; py = cy_v + d;
                            end
                            default:
                            begin
                                px = cx_v + d; py = cy_v - d;
                            end
                        endcase
                    end
                    default:
                    begin
                        px = cx_v;
                        py = cy_v;
                    end
                endcase
                send_point(px, py);
            end
            drain();
        end

        repeat (piast_pkg::LATENCY + 8) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #200000;
        $display("FAIL");
        $finish;
    end

endmodule
